// ===== rtl/core/rarm_pkg.sv =====
// ----------------------------------------------------------------------------
// rarm_pkg
// Shared widths, request codes, control word layout and the sequencer
// program for the rational add/multiply/reduce core.
// ----------------------------------------------------------------------------
package rarm_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int DEN_W         = OPERAND_WIDTH - 1;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int CNT_W         = $clog2(PROD_W);
  localparam int REQ_W         = 2;
  localparam int RES_NUM_W     = 32;
  localparam int RES_DEN_W     = 30;
  localparam int IN_DATA_W     = ((2 * OPERAND_WIDTH + 2 * DEN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W    = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_MUL  = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_CMP  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_Q,
    OP_MUL_D,
    OP_COMBINE,
    OP_GINIT,
    OP_GSTEP,
    OP_DSTART,
    OP_DSTEP,
    OP_DEND,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_BAD_REQ,
    C_IS_CMP,
    C_MAG_ZERO,
    C_GCD_BUSY,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_PROD_P   = 4'd1;
  localparam step_t S_PROD_Q   = 4'd2;
  localparam step_t S_PROD_D   = 4'd3;
  localparam step_t S_COMB     = 4'd4;
  localparam step_t S_GINIT    = 4'd5;
  localparam step_t S_GSTEP    = 4'd6;
  localparam step_t S_DSTART_M = 4'd7;
  localparam step_t S_DSTEP_M  = 4'd8;
  localparam step_t S_DEND_M   = 4'd9;
  localparam step_t S_DSTART_D = 4'd10;
  localparam step_t S_DSTEP_D  = 4'd11;
  localparam step_t S_DEND_D   = 4'd12;
  localparam step_t S_EMIT     = 4'd13;
  localparam step_t S_RET      = 4'd14;

  // sel_den: divider works on the denominator instead of the numerator
  typedef struct packed {
    op_t   op;
    logic  sel_den;
    cond_t cond;
    step_t target;
  } ctl_t;

  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w = '{op: OP_NOP, sel_den: 1'b0, cond: C_ALWAYS, target: S_WAIT};
    case (s)
      S_WAIT:     w = '{op: OP_LOAD,    sel_den: 1'b0, cond: C_NO_IN,    target: S_WAIT};
      S_PROD_P:   w = '{op: OP_MUL_P,   sel_den: 1'b0, cond: C_BAD_REQ,  target: S_EMIT};
      S_PROD_Q:   w = '{op: OP_MUL_Q,   sel_den: 1'b0, cond: C_NEXT,     target: S_WAIT};
      S_PROD_D:   w = '{op: OP_MUL_D,   sel_den: 1'b0, cond: C_NEXT,     target: S_WAIT};
      S_COMB:     w = '{op: OP_COMBINE, sel_den: 1'b0, cond: C_IS_CMP,   target: S_EMIT};
      S_GINIT:    w = '{op: OP_GINIT,   sel_den: 1'b0, cond: C_MAG_ZERO, target: S_EMIT};
      S_GSTEP:    w = '{op: OP_GSTEP,   sel_den: 1'b0, cond: C_GCD_BUSY, target: S_GSTEP};
      S_DSTART_M: w = '{op: OP_DSTART,  sel_den: 1'b0, cond: C_NEXT,     target: S_WAIT};
      S_DSTEP_M:  w = '{op: OP_DSTEP,   sel_den: 1'b0, cond: C_DIV_BUSY, target: S_DSTEP_M};
      S_DEND_M:   w = '{op: OP_DEND,    sel_den: 1'b0, cond: C_NEXT,     target: S_WAIT};
      S_DSTART_D: w = '{op: OP_DSTART,  sel_den: 1'b1, cond: C_NEXT,     target: S_WAIT};
      S_DSTEP_D:  w = '{op: OP_DSTEP,   sel_den: 1'b1, cond: C_DIV_BUSY, target: S_DSTEP_D};
      S_DEND_D:   w = '{op: OP_DEND,    sel_den: 1'b1, cond: C_NEXT,     target: S_WAIT};
      S_EMIT:     w = '{op: OP_EMIT,    sel_den: 1'b0, cond: C_OUT_BUSY, target: S_EMIT};
      S_RET:      w = '{op: OP_NOP,     sel_den: 1'b0, cond: C_ALWAYS,   target: S_WAIT};
      default:    w = '{op: OP_NOP,     sel_den: 1'b0, cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/rational_add_mul_reduce_core.sv =====
// ----------------------------------------------------------------------------
// rational_add_mul_reduce_core
// Fraction multiply, add and equality compare with gcd reduction, run by a
// small microprogram over one shared multiplier, a binary gcd unit and a
// bit-serial divider.
//
//   channel | dir | tdata (low bit up)                  | tuser
//   in_     | in  | a_num, a_den, b_num, b_den, zeros   | req_type
//   out_    | out | res_num, res_den, zeros             | is_equal
//
// Steps: accept, 3 multiply steps, combine, gcd init, gcd loop, two divides, emit,
// return; compare jumps from combine to emit, a zero result from gcd init, the
// unused code from the first multiply step. Gcd loop and divider dominate.
// Reset clears the step counter and the output valid; no clearing pass.
// A new request is taken while an earlier result still waits at the output;
// the emit step stalls until the output register is free.
// ----------------------------------------------------------------------------
module rational_add_mul_reduce_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // a_num, a_den, b_num, b_den, zero fill
  input  logic [rarm_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type
  input  logic [rarm_pkg::REQ_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // res_num, res_den, zero fill
  output logic [rarm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // is_equal
  output logic [0:0]                         out_tuser
);
  import rarm_pkg::*;

  localparam int A_NUM_LO = 0;
  localparam int A_DEN_LO = OPERAND_WIDTH;
  localparam int B_NUM_LO = OPERAND_WIDTH + DEN_W;
  localparam int B_DEN_LO = 2 * OPERAND_WIDTH + DEN_W;

  // sequencer
  step_t step_r, step_nxt;
  ctl_t  ctl;

  // operands
  req_t                     req_r, req_nxt;
  logic                     a_neg_r, a_neg_nxt, b_neg_r, b_neg_nxt;
  logic [OPERAND_WIDTH-1:0] a_mag_r, a_mag_nxt, b_mag_r, b_mag_nxt;
  logic [OPERAND_WIDTH-1:0] a_den_r, a_den_nxt, b_den_r, b_den_nxt;

  // products and working fraction
  logic [PROD_W-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [PROD_W-1:0] mag_r, mag_nxt, den_r, den_nxt;
  logic              neg_r, neg_nxt, eq_r, eq_nxt;

  // gcd and divider
  logic [PROD_W-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [PROD_W-1:0] quot_r, quot_nxt;
  logic [PROD_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [RES_NUM_W-1:0]    res_num_r, res_num_nxt;
  logic [RES_DEN_W-1:0]    res_den_r, res_den_nxt;
  logic                    res_eq_r, res_eq_nxt;

  // input decode
  logic [OPERAND_WIDTH-1:0] in_a_num, in_b_num;
  logic [DEN_W-1:0]         in_a_den, in_b_den;

  logic [OPERAND_WIDTH-1:0] mul_x, mul_y;
  logic [PROD_W-1:0]        mul_prod;
  logic [PROD_W:0]          trial;
  logic [63:0]              mag64, num64, den64;
  logic                     out_busy, cond_hit, a_zero, b_zero;

  assign in_a_num = in_tdata[A_NUM_LO +: OPERAND_WIDTH];
  assign in_a_den = in_tdata[A_DEN_LO +: DEN_W];
  assign in_b_num = in_tdata[B_NUM_LO +: OPERAND_WIDTH];
  assign in_b_den = in_tdata[B_DEN_LO +: DEN_W];

  assign ctl       = ucode(step_r);
  assign in_tready = (step_r == S_WAIT);
  assign out_busy  = out_valid_r && !out_tready;

  always_comb begin
    case (ctl.op)
      OP_MUL_P: begin
        mul_x = a_mag_r;
        mul_y = (req_r == REQ_MUL) ? b_mag_r : b_den_r;
      end
      OP_MUL_Q: begin
        mul_x = b_mag_r;
        mul_y = a_den_r;
      end
      default: begin
        mul_x = a_den_r;
        mul_y = b_den_r;
      end
    endcase
  end

  assign mul_prod = PROD_W'(mul_x) * PROD_W'(mul_y);
  assign trial    = {rem_r[PROD_W-1:0], quot_r[PROD_W-1]} - {1'b0, u_r};
  assign a_zero   = (a_mag_r == '0);
  assign b_zero   = (b_mag_r == '0);

  assign mag64 = 64'(mag_r);
  assign num64 = neg_r ? (~mag64 + 64'd1) : mag64;
  assign den64 = 64'(den_r);

  always_comb begin
    case (ctl.cond)
      C_NEXT:     cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_IN:    cond_hit = !in_tvalid;
      C_BAD_REQ:  cond_hit = (req_r == REQ_NONE);
      C_IS_CMP:   cond_hit = (req_r == REQ_CMP);
      C_MAG_ZERO: cond_hit = (mag_r == '0);
      C_GCD_BUSY: cond_hit = (u_r != v_r);
      C_DIV_BUSY: cond_hit = (cnt_r != CNT_W'(PROD_W - 1));
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    step_nxt = cond_hit ? ctl.target : step_r + step_t'(1);
  end

  always_comb begin
    req_nxt       = req_r;
    a_neg_nxt     = a_neg_r;
    b_neg_nxt     = b_neg_r;
    a_mag_nxt     = a_mag_r;
    b_mag_nxt     = b_mag_r;
    a_den_nxt     = a_den_r;
    b_den_nxt     = b_den_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    mag_nxt       = mag_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    eq_nxt        = eq_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    res_eq_nxt    = res_eq_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (ctl.op)
      OP_LOAD: begin
        if (in_tvalid) begin
          req_nxt   = req_t'(in_tuser);
          a_neg_nxt = in_a_num[OPERAND_WIDTH-1];
          b_neg_nxt = in_b_num[OPERAND_WIDTH-1];
          a_mag_nxt = in_a_num[OPERAND_WIDTH-1] ? (~in_a_num + OPERAND_WIDTH'(1)) : in_a_num;
          b_mag_nxt = in_b_num[OPERAND_WIDTH-1] ? (~in_b_num + OPERAND_WIDTH'(1)) : in_b_num;
          a_den_nxt = (in_a_den == '0) ? OPERAND_WIDTH'(1) : OPERAND_WIDTH'(in_a_den);
          b_den_nxt = (in_b_den == '0) ? OPERAND_WIDTH'(1) : OPERAND_WIDTH'(in_b_den);
        end
      end
      OP_MUL_P: p_nxt = mul_prod;
      OP_MUL_Q: q_nxt = mul_prod;
      OP_MUL_D: den_nxt = mul_prod;
      OP_COMBINE: begin
        eq_nxt = (a_zero && b_zero) ||
                 (!a_zero && !b_zero && (a_neg_r == b_neg_r) && (p_r == q_r));
        if (req_r == REQ_MUL) begin
          mag_nxt = p_r;
          neg_nxt = a_neg_r ^ b_neg_r;
        end else if (a_neg_r == b_neg_r) begin
          mag_nxt = p_r + q_r;
          neg_nxt = a_neg_r;
        end else if (p_r >= q_r) begin
          mag_nxt = p_r - q_r;
          neg_nxt = a_neg_r;
        end else begin
          mag_nxt = q_r - p_r;
          neg_nxt = b_neg_r;
        end
      end
      OP_GINIT: begin
        u_nxt = mag_r;
        v_nxt = den_r;
        if (mag_r == '0) begin
          neg_nxt = 1'b0;
          den_nxt = PROD_W'(1);
        end
      end
      OP_GSTEP: begin
        // common factors of two come out of the fraction directly
        if (u_r != v_r) begin
          if (!u_r[0] && !v_r[0]) begin
            u_nxt   = u_r >> 1;
            v_nxt   = v_r >> 1;
            mag_nxt = mag_r >> 1;
            den_nxt = den_r >> 1;
          end else if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else if (u_r > v_r) begin
            u_nxt = (u_r - v_r) >> 1;
          end else begin
            v_nxt = (v_r - u_r) >> 1;
          end
        end
      end
      OP_DSTART: begin
        rem_nxt  = '0;
        quot_nxt = ctl.sel_den ? den_r : mag_r;
        cnt_nxt  = '0;
      end
      OP_DSTEP: begin
        if (!trial[PROD_W]) begin
          rem_nxt  = trial;
          quot_nxt = {quot_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt  = {rem_r[PROD_W-1:0], quot_r[PROD_W-1]};
          quot_nxt = {quot_r[PROD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_DEND: begin
        if (ctl.sel_den) begin
          den_nxt = quot_r;
        end else begin
          mag_nxt = quot_r;
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          case (req_r)
            REQ_MUL, REQ_ADD: begin
              res_num_nxt = num64[RES_NUM_W-1:0];
              res_den_nxt = den64[RES_DEN_W-1:0];
              res_eq_nxt  = 1'b0;
            end
            REQ_CMP: begin
              res_num_nxt = '0;
              res_den_nxt = RES_DEN_W'(1);
              res_eq_nxt  = eq_r;
            end
            default: begin
              res_num_nxt = '0;
              res_den_nxt = RES_DEN_W'(1);
              res_eq_nxt  = 1'b0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    a_neg_r   <= a_neg_nxt;
    b_neg_r   <= b_neg_nxt;
    a_mag_r   <= a_mag_nxt;
    b_mag_r   <= b_mag_nxt;
    a_den_r   <= a_den_nxt;
    b_den_r   <= b_den_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    mag_r     <= mag_nxt;
    den_r     <= den_nxt;
    neg_r     <= neg_nxt;
    eq_r      <= eq_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    res_eq_r  <= res_eq_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RES_NUM_W - RES_DEN_W){1'b0}}, res_den_r, res_num_r};
  assign out_tuser  = res_eq_r;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (step_r == S_PROD_P))
    else $error("accepted request did not start the program");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == S_GSTEP) |-> ((u_r != '0) && (v_r != '0)))
    else $error("gcd operand reached zero");

  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    ((step_r == S_DEND_M) || (step_r == S_DEND_D)) |-> (rem_r == '0))
    else $error("reduction divide left a remainder");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_den_r != '0))
    else $error("result denominator is zero");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((step_r == S_EMIT) && out_valid_r && !out_tready) |=> (step_r == S_EMIT))
    else $error("emit step left while output was stalled");
`endif

endmodule

// ===== tb/sv/tb_rational_add_mul_reduce_core.sv =====
// ----------------------------------------------------------------------------
// tb_rational_add_mul_reduce_core
// Self-checking bench for the rational multiply/add/compare core. A directed
// table covers operand extremes, zero numerators, zero denominators, every
// request code and the unused code. Random requests with mixed operand
// classes then run through phases of sender gaps and output backpressure.
// Each result is checked field by field against a typed expectation or an in-bench fraction model.
// ----------------------------------------------------------------------------
module tb_rational_add_mul_reduce_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rarm_pkg::*;

  typedef bit [63:0] wide_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic [29:0]        den;
    logic               eq;
  } rational_result_t;

  typedef struct packed {
    req_t               op;
    logic signed [15:0] an;
    logic [14:0]        ad;
    logic signed [15:0] bn;
    logic [14:0]        bd;
    bit                 typed;
    rational_result_t   want;
  } stim_row_t;

  localparam int N_DIRECTED = 23;
  localparam int N_RANDOM   = 800;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [REQ_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  rational_result_t pending_results[$];
  int errors         = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{REQ_MUL,       0,     1,       0,     1, 1'b1, '{0, 1, 1'b0}},
    '{REQ_MUL,       1,     1,       1,     1, 1'b1, '{1, 1, 1'b0}},
    '{REQ_MUL,  -32768,     1,  -32768,     1, 1'b1, '{1073741824, 1, 1'b0}},
    '{REQ_MUL,   32767,     1,   32767,     1, 1'b1, '{1073676289, 1, 1'b0}},
    '{REQ_MUL,  -32768,     1,   32767,     1, 1'b1, '{-1073709056, 1, 1'b0}},
    '{REQ_MUL,       1, 32767,       1, 32767, 1'b1, '{1, 1073676289, 1'b0}},
    '{REQ_ADD,       0,     5,       0,     7, 1'b1, '{0, 1, 1'b0}},
    '{REQ_ADD,       1,     2,      -1,     2, 1'b1, '{0, 1, 1'b0}},
    '{REQ_ADD,   32767,     1,   32767,     1, 1'b1, '{65534, 1, 1'b0}},
    '{REQ_ADD,  -32768,     1,  -32768,     1, 1'b1, '{-65536, 1, 1'b0}},
    '{REQ_ADD,       1,     0,       1,     0, 1'b1, '{2, 1, 1'b0}},
    '{REQ_MUL,       3,     0,       5,     0, 1'b1, '{15, 1, 1'b0}},
    '{REQ_CMP,       1,     2,       2,     4, 1'b1, '{0, 1, 1'b1}},
    '{REQ_CMP,      -1,     2,       1,     2, 1'b1, '{0, 1, 1'b0}},
    '{REQ_CMP,       0,     7,       0,     3, 1'b1, '{0, 1, 1'b1}},
    '{REQ_CMP,       5,     0,       5,     1, 1'b1, '{0, 1, 1'b1}},
    '{REQ_NONE,    123,     4,      -5,     6, 1'b1, '{0, 1, 1'b0}},
    '{REQ_NONE, -32768, 32767,   32767,     0, 1'b1, '{0, 1, 1'b0}},
    '{REQ_ADD,   32767, 32767,  -32768, 32766, 1'b0, '{0, 1, 1'b0}},
    '{REQ_MUL,      12,    18,     -15,    20, 1'b0, '{0, 1, 1'b0}},
    '{REQ_ADD,      -7,     3,       5,     6, 1'b0, '{0, 1, 1'b0}},
    '{REQ_CMP,  -32768, 32767,  -32768, 32767, 1'b1, '{0, 1, 1'b1}},
    '{REQ_ADD,       1, 32767,       1, 32766, 1'b0, '{0, 1, 1'b0}}
  };

  rational_add_mul_reduce_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // divide out gcd(|mag|, den); zero reduces to 0/1
  function automatic void cancel_common(inout bit neg, inout wide_t mag, inout wide_t den);
    wide_t x, y, t;
    if (den == 0) den = 1;
    if (mag == 0) begin
      neg = 1'b0;
      den = 1;
      return;
    end
    x = mag;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mag = mag / x;
    den = den / x;
  endfunction

  function automatic rational_result_t compute_rational(req_t op,
      logic signed [15:0] an, logic [14:0] ad, logic signed [15:0] bn, logic [14:0] bd);
    rational_result_t r;
    wide_t am, bm, ade, bde, p, q, mag, den;
    bit a_neg, b_neg, neg;
    r = '{num: 0, den: 1, eq: 1'b0};
    a_neg = an < 0;
    b_neg = bn < 0;
    am = a_neg ? wide_t'(-int'(an)) : wide_t'(int'(an));
    bm = b_neg ? wide_t'(-int'(bn)) : wide_t'(int'(bn));
    ade = (ad == 0) ? 1 : wide_t'(ad);
    bde = (bd == 0) ? 1 : wide_t'(bd);
    case (op)
      REQ_NONE: return r;
      REQ_CMP: begin
        cancel_common(a_neg, am, ade);
        cancel_common(b_neg, bm, bde);
        r.eq = (a_neg == b_neg) && (am == bm) && (ade == bde);
        return r;
      end
      REQ_MUL: begin
        mag = am * bm;
        neg = a_neg != b_neg;
      end
      default: begin
        p = am * bde;
        q = bm * ade;
        if (a_neg == b_neg) begin
          mag = p + q;
          neg = a_neg;
        end else if (p >= q) begin
          mag = p - q;
          neg = a_neg;
        end else begin
          mag = q - p;
          neg = b_neg;
        end
      end
    endcase
    den = ade * bde;
    cancel_common(neg, mag, den);
    r.num = neg ? 32'(-mag) : 32'(mag);
    r.den = 30'(den);
    return r;
  endfunction

  function automatic logic signed [15:0] rand_num();
    case ($urandom_range(0, 3))
      0: return 16'(int'($urandom_range(0, 40)) - 20);
      1, 2: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'hffff;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [14:0] rand_den();
    case ($urandom_range(0, 3))
      0: return 15'($urandom_range(1, 30));
      1, 2: return 15'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return 15'd1;
          1: return 15'd32767;
          2: return 15'd0;
          default: return 15'd16384;
        endcase
      end
    endcase
  endfunction

  task automatic make_random_request(output req_t op, output logic signed [15:0] an,
      output logic [14:0] ad, output logic signed [15:0] bn, output logic [14:0] bd);
    int k;
    op = ($urandom_range(0, 99) < 5) ? REQ_NONE : req_t'($urandom_range(0, 2));
    an = rand_num();
    ad = rand_den();
    bn = rand_num();
    bd = rand_den();
    // equivalent fractions for compare: b = (a*k)/(a_den*k)
    if (op == REQ_CMP && $urandom_range(0, 1) == 1) begin
      k  = $urandom_range(1, 180);
      an = 16'(int'($urandom_range(0, 360)) - 180);
      ad = 15'($urandom_range(1, 180));
      bn = 16'(int'(an) * k);
      bd = 15'(int'(ad) * k);
    end
  endtask

  // request launched at a falling edge; returns at the falling edge after it is accepted
  task automatic send_request(req_t op, logic signed [15:0] an, logic [14:0] ad,
      logic signed [15:0] bn, logic [14:0] bd, rational_result_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, bd, bn, ad, an};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    rational_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending request: num %0d den %0d eq %0d",
               $signed(out_tdata[31:0]), out_tdata[61:32], out_tuser[0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if ($signed(out_tdata[31:0]) !== want.num) begin
          $error("res_num: expected %0d, got %0d", want.num, $signed(out_tdata[31:0]));
          errors++;
        end
        if (out_tdata[61:32] !== want.den) begin
          $error("res_den: expected %0d, got %0d", want.den, out_tdata[61:32]);
          errors++;
        end
        if (out_tuser[0] !== want.eq) begin
          $error("is_equal: expected %0d, got %0d", want.eq, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin : run_stimulus
    req_t op;
    logic signed [15:0] an, bn;
    logic [14:0] ad, bd;
    rational_result_t want;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want :
             compute_rational(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                              directed_rows[i].bn, directed_rows[i].bd);
      send_request(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                   directed_rows[i].bn, directed_rows[i].bd, want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
        default: begin send_gap_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        make_random_request(op, an, ad, bn, bd);
        send_request(op, an, ad, bn, bd, compute_rational(op, an, ad, bn, bd));
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
